### rtl/adpc_pkg.sv
// ----------------------------------------------------------------------------
// adpc_pkg: shared types and constants for the presence-sensing door controller
// Field widths, register indexes, door states and angle helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package adpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DistW  = 16;
  localparam int unsigned AngleW = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;

  localparam logic [AngleW-1:0] MaxAngle = 8'd180;
  localparam logic [AngleW-1:0] OpenAngleRst = 8'd90;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBaseline  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDebounce  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCloseDly  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOpenAng   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCloseAng  = 3'd6;

  typedef enum logic [1:0] {
    DOOR_CLOSED    = 2'd0,
    DOOR_OPEN      = 2'd1,
    DOOR_WAIT_CLOSE = 2'd2
  } door_e;

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic              dist_valid;
    logic [AngleW-1:0] remote_angle;
    logic              remote_cmd_valid;
    logic              remote_mode;
    logic [TimeW-1:0]  now_ms;
  } tick_t;

  typedef struct packed {
    door_e             door_state;
    logic [AngleW-1:0] servo_angle;
    logic              angle_write;
  } result_t;

  function automatic logic [AngleW-1:0] sat_angle(input logic [AngleW-1:0] a);
    return (a > MaxAngle) ? MaxAngle : a;
  endfunction

endpackage

`default_nettype wire

### rtl/auto_door_presence_controller.sv
// The result of a taken request goes to the result register, or to a skid
// register that keeps the slave side open while one result waits at a stalled
// head. Throughput: one request per cycle while the skid register is empty; the
// tick is evaluated in one compare-and-subtract pass ahead of the result register.
// Reset: asynchronous, active low; door closed, all timers zero, registers at
// their defaults, no result produced.
// ----------------------------------------------------------------------------
// auto_door_presence_controller
// Debounced distance-based presence detection, door state machine and
// remote servo override, one tick per request.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_door_presence_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [adpc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [adpc_pkg::CfgW-1:0]        cfg_data_i,
  // ticks in
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  // now_ms[31:0], remote_mode[32], remote_cmd_valid[33], remote_angle[41:34],
  // dist_valid[42], distance[58:43], zero[63:59]
  input  wire logic [adpc_pkg::InDataW-1:0]     s_axis_tdata_i,
  // results out
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // angle_write[0], servo_angle[8:1], door_state[10:9], zero[15:11]
  output      logic [adpc_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned ResW = $bits(adpc_pkg::result_t);

  // configuration
  logic [adpc_pkg::DistW-1:0]  baseline_q, threshold_q;
  logic [adpc_pkg::CfgW-1:0]   debounce_q, timeout_q, close_dly_q;
  logic [adpc_pkg::AngleW-1:0] open_ang_q, close_ang_q;

  // tick state
  adpc_pkg::door_e             door_q, door_d;
  logic [adpc_pkg::TimeW-1:0]  last_seen_q, last_seen_d;
  logic [adpc_pkg::TimeW-1:0]  close_start_q, close_start_d;
  logic [adpc_pkg::TimeW-1:0]  detect_start_q, detect_start_d;
  logic                        detecting_q, detecting_d;
  logic                        prev_remote_q;

  // output stage
  logic                        out_valid_q, out_valid_d;
  logic                        skid_valid_q, skid_valid_d;
  adpc_pkg::result_t           out_data_q, out_data_d;
  adpc_pkg::result_t           skid_data_q, skid_data_d;

  adpc_pkg::tick_t             tick;
  adpc_pkg::result_t           res;
  logic                        accept, drain;

  assign tick = adpc_pkg::tick_t'(s_axis_tdata_i[$bits(adpc_pkg::tick_t)-1:0]);

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign drain           = out_valid_q && m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(adpc_pkg::OutDataW-ResW){1'b0}}, out_data_q};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q  <= '0;
      threshold_q <= '0;
      debounce_q  <= '0;
      timeout_q   <= '0;
      close_dly_q <= '0;
      open_ang_q  <= adpc_pkg::OpenAngleRst;
      close_ang_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        adpc_pkg::CfgBaseline:  baseline_q  <= cfg_data_i;
        adpc_pkg::CfgThreshold: threshold_q <= cfg_data_i;
        adpc_pkg::CfgDebounce:  debounce_q  <= cfg_data_i;
        adpc_pkg::CfgTimeout:   timeout_q   <= cfg_data_i;
        adpc_pkg::CfgCloseDly:  close_dly_q <= cfg_data_i;
        adpc_pkg::CfgOpenAng:   open_ang_q  <= cfg_data_i[adpc_pkg::AngleW-1:0];
        adpc_pkg::CfgCloseAng:  close_ang_q <= cfg_data_i[adpc_pkg::AngleW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tick evaluation
  // ---------------------------------------------------------------------------
  logic                        leave;
  adpc_pkg::door_e             door_0;
  logic                        detecting_0;
  logic [adpc_pkg::TimeW-1:0]  last_seen_0, close_start_0, det_start_eff;
  logic signed [adpc_pkg::DistW+1:0] drop;
  logic                        detect, present;
  logic [adpc_pkg::TimeW-1:0]  det_elapsed, seen_elapsed, close_elapsed;

  always_comb begin
    leave        = prev_remote_q && !tick.remote_mode;
    door_0       = leave ? adpc_pkg::DOOR_CLOSED : door_q;
    last_seen_0  = leave ? tick.now_ms : last_seen_q;
    close_start_0 = leave ? '0 : close_start_q;
    detecting_0  = leave ? 1'b0 : detecting_q;

    drop   = $signed({2'b00, baseline_q}) - $signed({2'b00, tick.distance});
    detect = drop >= $signed({2'b00, threshold_q});

    det_start_eff = detecting_0 ? detect_start_q : tick.now_ms;
    det_elapsed   = tick.now_ms - det_start_eff;

    door_d         = door_0;
    last_seen_d    = last_seen_0;
    close_start_d  = close_start_0;
    detect_start_d = detect_start_q;
    detecting_d    = detecting_0;

    res.angle_write = leave;
    res.servo_angle = leave ? adpc_pkg::sat_angle(close_ang_q) : '0;

    if (tick.remote_mode) begin
      if (tick.remote_cmd_valid) begin
        res.angle_write = 1'b1;
        res.servo_angle = adpc_pkg::sat_angle(tick.remote_angle);
      end
    end else if (tick.dist_valid) begin
      if (detect) begin
        detecting_d    = 1'b1;
        detect_start_d = det_start_eff;
        if (det_elapsed >= {{(adpc_pkg::TimeW-adpc_pkg::CfgW){1'b0}}, debounce_q}) begin
          last_seen_d = tick.now_ms;
        end
      end else begin
        detecting_d = 1'b0;
      end
    end

    seen_elapsed  = tick.now_ms - last_seen_d;
    close_elapsed = tick.now_ms - close_start_0;
    present = seen_elapsed < {{(adpc_pkg::TimeW-adpc_pkg::CfgW){1'b0}}, timeout_q};

    if (!tick.remote_mode && tick.dist_valid) begin
      case (door_0)
        adpc_pkg::DOOR_OPEN: begin
          if (!present) begin
            door_d        = adpc_pkg::DOOR_WAIT_CLOSE;
            close_start_d = tick.now_ms;
          end
        end
        adpc_pkg::DOOR_WAIT_CLOSE: begin
          if (present) begin
            door_d = adpc_pkg::DOOR_OPEN;
          end else if (close_elapsed >=
                       {{(adpc_pkg::TimeW-adpc_pkg::CfgW){1'b0}}, close_dly_q}) begin
            door_d          = adpc_pkg::DOOR_CLOSED;
            res.angle_write = 1'b1;
            res.servo_angle = adpc_pkg::sat_angle(close_ang_q);
          end
        end
        default: begin
          door_d = adpc_pkg::DOOR_CLOSED;
          if (present) begin
            door_d          = adpc_pkg::DOOR_OPEN;
            res.angle_write = 1'b1;
            res.servo_angle = adpc_pkg::sat_angle(open_ang_q);
          end
        end
      endcase
    end

    res.door_state = door_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q         <= adpc_pkg::DOOR_CLOSED;
      last_seen_q    <= '0;
      close_start_q  <= '0;
      detect_start_q <= '0;
      detecting_q    <= 1'b0;
      prev_remote_q  <= 1'b0;
    end else if (accept) begin
      door_q         <= door_d;
      last_seen_q    <= last_seen_d;
      close_start_q  <= close_start_d;
      detect_start_q <= detect_start_d;
      detecting_q    <= detecting_d;
      prev_remote_q  <= tick.remote_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register with skid stage
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // slave side is closed; move the parked result up once the head drains
      if (drain) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || drain) begin
        out_data_d  = res;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = res;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

`default_nettype wire
